>>> rtl/wrht_pkg.sv
// Shared types and codes for the window rectangle table hit test.
// Used by the table core and the port checker.
package wrht_pkg;

    localparam int MaxWindowsDefault = 16;
    localparam int CoordW            = 16;
    localparam int IndexW            = 4;
    localparam int CountOutW         = 5;
    localparam int ActionW           = 3;
    localparam int StatusW           = 3;

    typedef enum logic [ActionW-1:0] {
        ACT_ADD    = 3'd0,
        ACT_CLOSE  = 3'd1,
        ACT_MOVE   = 3'd2,
        ACT_RESIZE = 3'd3,
        ACT_QUERY  = 3'd4
    } action_t;

    typedef enum logic [StatusW-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_INDEX = 3'd1,
        STATUS_EMPTY     = 3'd2,
        STATUS_NEG_SIZE  = 3'd3,
        STATUS_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MODIFY,
        S_SCAN,
        S_REPLY
    } state_t;

    // One table entry as stored in the memory
    typedef struct packed {
        logic signed [CoordW-1:0] left;
        logic signed [CoordW-1:0] top;
        logic signed [CoordW-1:0] width;
        logic signed [CoordW-1:0] height;
    } window_t;

endpackage

>>> rtl/window_rectangle_table_hit_test.sv
// Window rectangle table with pixel hit test: top level.
// Depends on wrht_pkg and wrht_ram.
//
// Keeps a stack of up to MAX_WINDOWS rectangles (left, top, width, height) in one
// synchronous RAM and handles one request at a time: add, close last, move, resize,
// or pixel query. Add and close pass through the execute and reply states; move and
// resize add a modify state between them (read, modify, write back through the single
// RAM port pair). A pixel query steps through the stored windows in a scan state,
// starting from the bottom of the stack, because the RAM read port delivers
// one stored window per cycle to the hit comparator. A new request is taken as soon
// as the previous result sits in the output register, even while it waits for
// out_ready. Moves wrap in 16-bit two's complement; right and bottom bounds of the
// hit test are formed at 17 bits and never wrap.
module window_rectangle_table_hit_test #(
    parameter int MAX_WINDOWS = wrht_pkg::MaxWindowsDefault
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [wrht_pkg::ActionW-1:0]               action,
    input  logic [wrht_pkg::IndexW-1:0]                window_index,
    input  logic signed [wrht_pkg::CoordW-1:0]         left,
    input  logic signed [wrht_pkg::CoordW-1:0]         top,
    input  logic signed [wrht_pkg::CoordW-1:0]         width,
    input  logic signed [wrht_pkg::CoordW-1:0]         height,
    input  logic signed [wrht_pkg::CoordW-1:0]         delta_x,
    input  logic signed [wrht_pkg::CoordW-1:0]         delta_y,
    input  logic signed [wrht_pkg::CoordW-1:0]         pixel_col,
    input  logic signed [wrht_pkg::CoordW-1:0]         pixel_row,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [wrht_pkg::StatusW-1:0]               status,
    output logic                                       covered,
    output logic [wrht_pkg::CountOutW-1:0]             window_count,
    output logic signed [wrht_pkg::CoordW-1:0]         win_left,
    output logic signed [wrht_pkg::CoordW-1:0]         win_top,
    output logic signed [wrht_pkg::CoordW-1:0]         win_width,
    output logic signed [wrht_pkg::CoordW-1:0]         win_height
);

    import wrht_pkg::*;

    localparam int AW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CW = $clog2(MAX_WINDOWS + 1);
    localparam int EW = IndexW + CW;
    localparam int WW = $bits(window_t);

    // Pixel position against one axis of a window, bounds at 17 bits
    function automatic logic axis_hit(
        input logic signed [CoordW-1:0] pos,
        input logic signed [CoordW-1:0] start,
        input logic signed [CoordW-1:0] size
    );
        logic signed [CoordW:0] p;
        logic signed [CoordW:0] s;
        logic signed [CoordW:0] e;
        p = {pos[CoordW-1], pos};
        s = {start[CoordW-1], start};
        e = s + {size[CoordW-1], size};
        return (p >= s) && (p < e);
    endfunction

    // Control state
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic            hit_reg, hit_next;
    logic            out_valid_reg, out_valid_next;

    // Captured request
    action_t                  req_action_reg, req_action_next;
    logic [IndexW-1:0]        req_index_reg, req_index_next;
    window_t                  req_win_reg, req_win_next;
    logic signed [CoordW-1:0] req_dx_reg, req_dx_next;
    logic signed [CoordW-1:0] req_dy_reg, req_dy_next;
    logic signed [CoordW-1:0] req_col_reg, req_col_next;
    logic signed [CoordW-1:0] req_row_reg, req_row_next;

    // Pending result and output register
    status_t           res_status_reg, res_status_next;
    logic              res_covered_reg, res_covered_next;
    window_t           res_win_reg, res_win_next;
    status_t           out_status_reg, out_status_next;
    logic              out_covered_reg, out_covered_next;
    logic [CountOutW-1:0] out_count_reg, out_count_next;
    window_t           out_win_reg, out_win_next;

    // Memory port
    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    window_t         ram_wr_data;
    logic            ram_rd_en;
    logic [AW-1:0]   ram_rd_addr;
    logic [WW-1:0]   ram_rd_bits;
    window_t         rd_win;

    // Derived request checks
    logic            tbl_empty;
    logic            tbl_full;
    logic            index_ok;
    logic [EW-1:0]   index_wide;
    logic [EW-1:0]   count_wide;
    logic [IndexW+AW-1:0] index_ext;
    logic [CW+CountOutW-1:0] count_out_ext;
    logic            entry_hit;
    window_t         mod_win;

    assign rd_win        = window_t'(ram_rd_bits);
    assign tbl_empty     = (count_reg == '0);
    assign tbl_full      = (count_reg == CW'(MAX_WINDOWS));
    assign index_wide    = EW'(req_index_reg);
    assign count_wide    = EW'(count_reg);
    assign index_ok      = (index_wide < count_wide);
    assign index_ext     = (IndexW + AW)'(req_index_reg);
    assign count_out_ext = (CW + CountOutW)'(count_reg);
    assign entry_hit     = axis_hit(req_col_reg, rd_win.left, rd_win.width)
                         && axis_hit(req_row_reg, rd_win.top, rd_win.height);

    wrht_ram #(
        .WIDTH(WW),
        .DEPTH(MAX_WINDOWS)
    ) u_table (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_bits)
    );

    // Sequencer: next state, memory accesses, result formation
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        hit_next         = hit_reg;
        out_valid_next   = out_valid_reg;
        req_action_next  = req_action_reg;
        req_index_next   = req_index_reg;
        req_win_next     = req_win_reg;
        req_dx_next      = req_dx_reg;
        req_dy_next      = req_dy_reg;
        req_col_next     = req_col_reg;
        req_row_next     = req_row_reg;
        res_status_next  = res_status_reg;
        res_covered_next = res_covered_reg;
        res_win_next     = res_win_reg;
        out_status_next  = out_status_reg;
        out_covered_next = out_covered_reg;
        out_count_next   = out_count_reg;
        out_win_next     = out_win_reg;
        ram_wr_en        = 1'b0;
        ram_wr_addr      = count_reg[AW-1:0];
        ram_wr_data      = req_win_reg;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = '0;
        mod_win          = rd_win;
        in_ready         = (state_reg == S_IDLE);

        // drop the output once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_action_next  = action_t'(action);
                    req_index_next   = window_index;
                    req_win_next     = '{left: left, top: top, width: width,
                                         height: height};
                    req_dx_next      = delta_x;
                    req_dy_next      = delta_y;
                    req_col_next     = pixel_col;
                    req_row_next     = pixel_row;
                    state_next       = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_status_next  = STATUS_OK;
                res_covered_next = 1'b0;
                res_win_next     = '0;
                state_next       = S_REPLY;
                unique case (req_action_reg) inside
                    ACT_ADD:
                    begin
                        if (tbl_full)
                        begin
                            res_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            ram_wr_en  = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    ACT_CLOSE:
                    begin
                        if (tbl_empty)
                        begin
                            res_status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    ACT_MOVE, ACT_RESIZE:
                    begin
                        if (tbl_empty)
                        begin
                            res_status_next = STATUS_EMPTY;
                        end
                        else if (!index_ok)
                        begin
                            res_status_next = STATUS_BAD_INDEX;
                        end
                        else
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = index_ext[AW-1:0];
                            state_next  = S_MODIFY;
                        end
                    end
                    ACT_QUERY:
                    begin
                        // start the scan at the bottom of the stack
                        if (!tbl_empty)
                        begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = '0;
                            ptr_next    = CW'(1);
                            hit_next    = 1'b0;
                            state_next  = S_SCAN;
                        end
                    end
                    default:
                    begin
                        res_status_next = STATUS_OK;
                    end
                endcase
            end

            S_MODIFY:
            begin
                // read data is back: modify and write back, unless a resize has a negative size
                ram_wr_addr = index_ext[AW-1:0];
                if (req_action_reg == ACT_MOVE)
                begin
                    mod_win.left = rd_win.left + req_dx_reg;
                    mod_win.top  = rd_win.top + req_dy_reg;
                    ram_wr_en    = 1'b1;
                end
                else if (req_win_reg.width[CoordW-1] || req_win_reg.height[CoordW-1])
                begin
                    res_status_next = STATUS_NEG_SIZE;
                end
                else
                begin
                    mod_win.width  = req_win_reg.width;
                    mod_win.height = req_win_reg.height;
                    ram_wr_en      = 1'b1;
                end
                ram_wr_data  = mod_win;
                res_win_next = mod_win;
                state_next   = S_REPLY;
            end

            S_SCAN:
            begin
                // test one entry per cycle, issue the next read
                if (ptr_reg < count_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ptr_reg[AW-1:0];
                    ptr_next    = ptr_reg + 1'b1;
                    hit_next    = hit_reg | entry_hit;
                end
                else
                begin
                    res_covered_next = hit_reg | entry_hit;
                    state_next       = S_REPLY;
                end
            end

            S_REPLY:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = res_status_reg;
                    out_covered_next = res_covered_reg;
                    out_count_next   = count_out_ext[CountOutW-1:0];
                    out_win_next     = res_win_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg         <= ptr_next;
        hit_reg         <= hit_next;
        req_action_reg  <= req_action_next;
        req_index_reg   <= req_index_next;
        req_win_reg     <= req_win_next;
        req_dx_reg      <= req_dx_next;
        req_dy_reg      <= req_dy_next;
        req_col_reg     <= req_col_next;
        req_row_reg     <= req_row_next;
        res_status_reg  <= res_status_next;
        res_covered_reg <= res_covered_next;
        res_win_reg     <= res_win_next;
        out_status_reg  <= out_status_next;
        out_covered_reg <= out_covered_next;
        out_count_reg   <= out_count_next;
        out_win_reg     <= out_win_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign covered      = out_covered_reg;
    assign window_count = out_count_reg;
    assign win_left     = out_win_reg.left;
    assign win_top      = out_win_reg.top;
    assign win_width    = out_win_reg.width;
    assign win_height   = out_win_reg.height;

endmodule

>>> rtl/wrht_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No package dependency.
module wrht_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/wrht_checker.sv
// Port-level checks for the window rectangle table hit test, bound to the top level.
// Depends on wrht_pkg.
module wrht_checker #(
    parameter int MAX_WINDOWS = wrht_pkg::MaxWindowsDefault
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [wrht_pkg::StatusW-1:0]        status,
    input logic                                covered,
    input logic [wrht_pkg::CountOutW-1:0]      window_count,
    input logic signed [wrht_pkg::CoordW-1:0]  win_left,
    input logic signed [wrht_pkg::CoordW-1:0]  win_top,
    input logic signed [wrht_pkg::CoordW-1:0]  win_width,
    input logic signed [wrht_pkg::CoordW-1:0]  win_height
);

    import wrht_pkg::*;

    // Hold the status, covered flag and count of a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(covered)
            && $stable(window_count))
        else $error("stalled result changed");

    // One request at a time: no back-to-back acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // A hit is only reported with ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && covered |-> status == STATUS_OK)
        else $error("covered set on failed request");

    // Full table reports the maximum count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_FULL |-> window_count == CountOutW'(MAX_WINDOWS))
        else $error("full status with wrong count");

    // Window fields only on a successful or size-rejected move/resize
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (win_left != 0 || win_top != 0 || win_width != 0 || win_height != 0)
            |-> (status == STATUS_OK || status == STATUS_NEG_SIZE) && !covered)
        else $error("window fields on unexpected result");

endmodule

bind window_rectangle_table_hit_test wrht_checker #(
    .MAX_WINDOWS(MAX_WINDOWS)
) u_wrht_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .covered     (covered),
    .window_count(window_count),
    .win_left    (win_left),
    .win_top     (win_top),
    .win_width   (win_width),
    .win_height  (win_height)
);
